// File: rtl/fpbs_pkg.sv
// Package for the farthest-pair bounding sphere block.
// Holds widths, queue word type, back-end state enum. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fpbs_pkg;
   localparam int CoordW = 24;
   localparam int DistW  = 50;

   typedef struct packed {
      logic signed [CoordW-1:0] x;
      logic signed [CoordW-1:0] y;
      logic signed [CoordW-1:0] z;
      logic                     last;
   } point_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_RD, ST_DIFF, ST_SQ, ST_SUM, ST_CMP, ST_WR, ST_FETCH_F, ST_FETCH_S,
      ST_SQRT, ST_OUT
   } back_state_type;
endpackage
`default_nettype wire

// File: rtl/fpbs_front.sv
// Front end: two-entry queue toward the back end.
// Depends on fpbs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fpbs_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   in_valid,
   output logic                  in_ready,
   input  fpbs_pkg::point_type   in_word,
   output logic                  out_valid,
   input  wire                   out_ready,
   output fpbs_pkg::point_type   out_word
);
   import fpbs_pkg::*;

   point_type  q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in;
   logic       wr_ff, wr_in;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_word  = q_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
      rd_in  = rd_ff ^ pop;
      wr_in  = wr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
      end
      if (push) q_ff[wr_ff] <= in_word;
   end
endmodule
`default_nettype wire

// File: rtl/fpbs_back.sv
// Back end: point store, shared squared-distance unit, pair search, root, center.
// Depends on fpbs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fpbs_back #(
   parameter int MAX_POINTS = 256
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        in_valid,
   output logic                       in_ready,
   input  fpbs_pkg::point_type        in_word,
   output logic                       out_valid,
   input  wire                        out_ready,
   output logic [23:0]                out_radius,
   output logic signed [23:0]         out_cx,
   output logic signed [23:0]         out_cy,
   output logic signed [23:0]         out_cz,
   output logic                       out_dropped
);
   import fpbs_pkg::*;

   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = AW + 1;

   logic signed [CoordW-1:0] mem_x [MAX_POINTS];
   logic signed [CoordW-1:0] mem_y [MAX_POINTS];
   logic signed [CoordW-1:0] mem_z [MAX_POINTS];

   back_state_type st_ff, st_in;
   point_type      cur_ff;
   logic [CW-1:0]  cnt_ff, idx_ff;
   logic [DistW-1:0] best_ff;
   logic [AW-1:0]  bf_ff, bs_ff;
   logic           ovf_ff;
   logic [AW-1:0]  raddr;
   logic signed [CoordW-1:0] rx_ff, ry_ff, rz_ff;
   logic [CoordW:0] dx_ff, dy_ff, dz_ff;
   logic [2*CoordW-1:0] sx_ff, sy_ff, sz_ff;
   logic [DistW-1:0] d_ff;
   logic signed [CoordW-1:0] fx_ff, fy_ff, fz_ff;
   logic [DistW-1:0] rem_ff;
   logic [25:0]    root_ff;
   logic [4:0]     sq_ff;
   logic [DistW-1:0] trial;
   logic [CoordW:0] sumx, sumy, sumz;
   logic [CoordW:0] ad, bd, cd;

   assign in_ready  = (st_ff == ST_IDLE);
   assign out_valid = (st_ff == ST_OUT);

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: if (in_valid) st_in = (cnt_ff >= CW'(MAX_POINTS)) ?
                                        (in_word.last ? ST_FETCH_F : ST_IDLE) : ST_RD;
         ST_RD:   st_in = (idx_ff == cnt_ff) ? ST_WR : ST_DIFF;
         ST_DIFF: st_in = ST_SQ;
         ST_SQ:   st_in = ST_SUM;
         ST_SUM:  st_in = ST_CMP;
         ST_CMP:  st_in = ST_RD;
         ST_WR:   st_in = cur_ff.last ? ST_FETCH_F : ST_IDLE;
         ST_FETCH_F: st_in = ST_FETCH_S;
         ST_FETCH_S: st_in = ST_SQRT;
         ST_SQRT: if (sq_ff == 5'd0) st_in = ST_OUT;
         ST_OUT:  if (out_ready) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_comb begin
      case (st_ff)
         ST_FETCH_F: raddr = bf_ff;
         ST_FETCH_S, ST_SQRT, ST_OUT: raddr = bs_ff;
         default:    raddr = idx_ff[AW-1:0];
      endcase
      trial = rem_ff - ({24'd0, root_ff} << (sq_ff * 2 + 2)) - (50'd1 << (sq_ff * 2));
      ad = {rx_ff[CoordW-1], rx_ff} - {cur_ff.x[CoordW-1], cur_ff.x};
      bd = {ry_ff[CoordW-1], ry_ff} - {cur_ff.y[CoordW-1], cur_ff.y};
      cd = {rz_ff[CoordW-1], rz_ff} - {cur_ff.z[CoordW-1], cur_ff.z};
      sumx = {fx_ff[CoordW-1], fx_ff} + {rx_ff[CoordW-1], rx_ff};
      sumy = {fy_ff[CoordW-1], fy_ff} + {ry_ff[CoordW-1], ry_ff};
      sumz = {fz_ff[CoordW-1], fz_ff} + {rz_ff[CoordW-1], rz_ff};
   end

   assign out_radius  = root_ff[24:1];
   assign out_cx      = sumx[CoordW:1];
   assign out_cy      = sumy[CoordW:1];
   assign out_cz      = sumz[CoordW:1];
   assign out_dropped = ovf_ff;

   always_ff @(posedge clock) begin
      rx_ff <= mem_x[raddr];
      ry_ff <= mem_y[raddr];
      rz_ff <= mem_z[raddr];
      if (st_ff == ST_WR) begin
         mem_x[cnt_ff[AW-1:0]] <= cur_ff.x;
         mem_y[cnt_ff[AW-1:0]] <= cur_ff.y;
         mem_z[cnt_ff[AW-1:0]] <= cur_ff.z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         cnt_ff <= '0;
         best_ff <= '0;
         bf_ff <= '0;
         bs_ff <= '0;
         ovf_ff <= 1'b0;
         idx_ff <= '0;
         sq_ff <= '0;
      end else begin
         st_ff <= st_in;
         case (st_ff)
            ST_IDLE: if (in_valid) begin
               cur_ff <= in_word;
               idx_ff <= '0;
               if (cnt_ff >= CW'(MAX_POINTS)) ovf_ff <= 1'b1;
            end
            ST_DIFF: begin
               dx_ff <= ad[CoordW] ? -ad : ad;
               dy_ff <= bd[CoordW] ? -bd : bd;
               dz_ff <= cd[CoordW] ? -cd : cd;
            end
            ST_SQ: begin
               sx_ff <= dx_ff[CoordW-1:0] * dx_ff[CoordW-1:0];
               sy_ff <= dy_ff[CoordW-1:0] * dy_ff[CoordW-1:0];
               sz_ff <= dz_ff[CoordW-1:0] * dz_ff[CoordW-1:0];
            end
            ST_SUM: d_ff <= {2'b0, sx_ff} + {2'b0, sy_ff} + {2'b0, sz_ff};
            ST_CMP: begin
               if (d_ff > best_ff ||
                   (d_ff != '0 && d_ff == best_ff && idx_ff[AW-1:0] < bf_ff)) begin
                  best_ff <= d_ff;
                  bf_ff <= idx_ff[AW-1:0];
                  bs_ff <= cnt_ff[AW-1:0];
               end
               idx_ff <= idx_ff + 1'b1;
            end
            ST_WR: cnt_ff <= cnt_ff + 1'b1;
            ST_FETCH_S: begin
               fx_ff <= rx_ff;
               fy_ff <= ry_ff;
               fz_ff <= rz_ff;
               rem_ff <= best_ff;
               root_ff <= '0;
               sq_ff <= 5'd24;
            end
            ST_SQRT: begin
               if (!trial[DistW-1] && (rem_ff >= ({24'd0, root_ff} << (sq_ff * 2 + 2))
                   + (50'd1 << (sq_ff * 2)))) begin
                  rem_ff <= trial;
                  root_ff <= (root_ff << 1) | 26'd1;
               end else begin
                  root_ff <= root_ff << 1;
               end
               if (sq_ff != 5'd0) sq_ff <= sq_ff - 1'b1;
            end
            ST_OUT: if (out_ready) begin
               cnt_ff <= '0;
               best_ff <= '0;
               bf_ff <= '0;
               bs_ff <= '0;
               ovf_ff <= 1'b0;
            end
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

// File: rtl/farthest_pair_bounding_sphere.sv
// Farthest-pair bounding sphere: each point that fits in the store is compared with all
// stored points through one shared squared-distance unit (read, difference, square, sum,
// compare). A point that arrives when the store is full is dropped uncompared and flagged.
// The back end takes no new point until done with the last; the input queue sits ahead of it.
// The final point adds two fetches, a 25-step root and an output word held until taken.
// Reset is synchronous and clears counts, best pair and flags; the store is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module farthest_pair_bounding_sphere #(
   parameter int MAX_POINTS = 256
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  wire signed [23:0]  req_point_x,
   input  wire signed [23:0]  req_point_y,
   input  wire signed [23:0]  req_point_z,
   input  wire                req_last_point,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output logic [23:0]        rsp_radius,
   output logic signed [23:0] rsp_center_x,
   output logic signed [23:0] rsp_center_y,
   output logic signed [23:0] rsp_center_z,
   output logic               rsp_points_dropped
);
   import fpbs_pkg::*;

   point_type in_w, q_w;
   logic      q_valid, q_ready;

   assign in_w = '{x: req_point_x, y: req_point_y, z: req_point_z, last: req_last_point};

   fpbs_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_ready(req_ready), .in_word(in_w),
      .out_valid(q_valid), .out_ready(q_ready), .out_word(q_w)
   );

   fpbs_back #(.MAX_POINTS(MAX_POINTS)) u_back (
      .clock(clock), .reset(reset),
      .in_valid(q_valid), .in_ready(q_ready), .in_word(q_w),
      .out_valid(rsp_valid), .out_ready(rsp_ready),
      .out_radius(rsp_radius), .out_cx(rsp_center_x), .out_cy(rsp_center_y),
      .out_cz(rsp_center_z), .out_dropped(rsp_points_dropped)
   );
endmodule
`default_nettype wire

// File: tb/sv/tb_farthest_pair_bounding_sphere.sv
// Testbench for farthest_pair_bounding_sphere: streams point sets, predicts each sphere.
// Depends on rtl/fpbs_pkg.sv and rtl/farthest_pair_bounding_sphere.sv.
`timescale 1ns / 1ps
module tb_farthest_pair_bounding_sphere;
   import fpbs_pkg::*;

   localparam int Depth = 256;
   localparam logic signed [23:0] CMax = 24'sh7FFFFF;
   localparam logic signed [23:0] CMin = -24'sh800000;

   typedef struct {
      logic [23:0]        radius;
      logic signed [23:0] cx;
      logic signed [23:0] cy;
      logic signed [23:0] cz;
      logic               dropped;
   } sphere_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [23:0] req_point_x = '0;
   logic signed [23:0] req_point_y = '0;
   logic signed [23:0] req_point_z = '0;
   logic req_last_point = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [23:0] rsp_radius;
   logic signed [23:0] rsp_center_x, rsp_center_y, rsp_center_z;
   logic rsp_points_dropped;

   farthest_pair_bounding_sphere u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_point_x(req_point_x), .req_point_y(req_point_y),
      .req_point_z(req_point_z), .req_last_point(req_last_point),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_radius(rsp_radius), .rsp_center_x(rsp_center_x),
      .rsp_center_y(rsp_center_y), .rsp_center_z(rsp_center_z),
      .rsp_points_dropped(rsp_points_dropped)
   );

   // predictor state
   logic signed [23:0] pts_x [Depth];
   logic signed [23:0] pts_y [Depth];
   logic signed [23:0] pts_z [Depth];
   int unsigned        n_stored;
   longint unsigned    far_d2;
   int unsigned        far_i, far_j;
   bit                 overflowed;

   sphere_type expected_spheres[$];
   int  errors = 0;
   int  items_sent = 0;
   bit  quiet = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #80ms;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic logic signed [23:0] mid(input logic signed [23:0] a,
                                               input logic signed [23:0] b);
      longint s;
      s = longint'(a) + longint'(b);
      s = s >>> 1;
      return s[23:0];
   endfunction

   function automatic void clear_set();
      n_stored = 0;
      far_d2 = 0;
      far_i = 0;
      far_j = 0;
      overflowed = 0;
   endfunction

   function automatic void predict_point(input logic signed [23:0] x, y, z,
                                         input bit last, output bit emit,
                                         output sphere_type s);
      longint dx, dy, dz;
      longint unsigned d;
      if (n_stored >= Depth) begin
         overflowed = 1;
      end else begin
         for (int unsigned i = 0; i < n_stored; i++) begin
            dx = longint'(pts_x[i]) - longint'(x);
            dy = longint'(pts_y[i]) - longint'(y);
            dz = longint'(pts_z[i]) - longint'(z);
            d = dx * dx + dy * dy + dz * dz;
            if (d > far_d2 || (d != 0 && d == far_d2 && i < far_i)) begin
               far_d2 = d;
               far_i = i;
               far_j = n_stored;
            end
         end
         pts_x[n_stored] = x;
         pts_y[n_stored] = y;
         pts_z[n_stored] = z;
         n_stored++;
      end
      emit = last;
      s = '{default: '0};
      if (last) begin
         s.radius = 24'(int_sqrt(far_d2) >> 1);
         s.cx = mid(pts_x[far_i], pts_x[far_j]);
         s.cy = mid(pts_y[far_i], pts_y[far_j]);
         s.cz = mid(pts_z[far_i], pts_z[far_j]);
         s.dropped = overflowed;
         clear_set();
      end
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      errors++;
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
   endtask

   // one word per accepted handshake
   task automatic send_point(input logic signed [23:0] x, y, z, input bit last);
      int gap;
      bit emit;
      sphere_type s;
      gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_point_x <= x;
      req_point_y <= y;
      req_point_z <= z;
      req_last_point <= last;
      do @(posedge clock); while (!(req_valid && req_ready));
      predict_point(x, y, z, last, emit, s);
      if (emit) expected_spheres.push_back(s);
      items_sent++;
   endtask

   always @(posedge clock) begin
      int hold;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_spheres.size() == 0) begin
               report_mismatch("unexpected word", 1, 0);
            end else begin
               sphere_type e;
               e = expected_spheres.pop_front();
               if (rsp_radius !== e.radius) report_mismatch("radius", rsp_radius, e.radius);
               if (rsp_center_x !== e.cx) report_mismatch("center_x", rsp_center_x, e.cx);
               if (rsp_center_y !== e.cy) report_mismatch("center_y", rsp_center_y, e.cy);
               if (rsp_center_z !== e.cz) report_mismatch("center_z", rsp_center_z, e.cz);
               if (rsp_points_dropped !== e.dropped)
                  report_mismatch("points_dropped", rsp_points_dropped, e.dropped);
            end
         end
         if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            hold = $urandom_range(0, 5);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic logic signed [23:0] rand_coord(input int mode);
      case (mode)
         0: return 24'($urandom());
         1: return 24'($urandom_range(0, 6) - 3);
         2: return $urandom_range(0, 1) ? CMax : CMin;
         default: return 24'($urandom_range(0, 2000) - 1000);
      endcase
   endfunction

   task automatic test_extremes();
      send_point(CMin, CMin, CMin, 0);
      send_point(CMax, CMax, CMax, 0);
      send_point(24'sd0, 24'sd0, 24'sd0, 1);
      send_point(CMax, CMin, CMax, 0);
      send_point(CMin, CMax, CMin, 1);
      send_point(-24'sd1, 24'sd1, -24'sd3, 0);
      send_point(24'sd0, 24'sd0, 24'sd0, 1);
   endtask

   task automatic test_single_and_coincident();
      send_point(24'sd1234, -24'sd77, CMax, 1);
      send_point(CMin, 24'sd5, 24'sd9, 1);
      repeat (4) send_point(-24'sd300, 24'sd300, 24'sd7, 0);
      send_point(-24'sd300, 24'sd300, 24'sd7, 1);
   endtask

   task automatic test_ties();
      // equidistant pairs in several orders
      send_point(24'sd0, 24'sd0, 24'sd0, 0);
      send_point(24'sd10, 24'sd0, 24'sd0, 0);
      send_point(24'sd0, 24'sd10, 24'sd0, 0);
      send_point(24'sd0, 24'sd0, 24'sd10, 1);
      send_point(24'sd5, 24'sd5, 24'sd0, 0);
      send_point(-24'sd5, -24'sd5, 24'sd0, 0);
      send_point(24'sd5, -24'sd5, 24'sd0, 0);
      send_point(-24'sd5, 24'sd5, 24'sd0, 1);
   endtask

   task automatic test_store_full();
      for (int k = 0; k < Depth; k++) send_point(rand_coord(0), rand_coord(0), rand_coord(0), 0);
      send_point(CMax, CMax, CMax, 0);
      send_point(CMin, CMin, CMin, 1);
      for (int k = 0; k < Depth + 1; k++)
         send_point(rand_coord(3), rand_coord(3), rand_coord(3), 0);
      send_point(24'sd3, 24'sd3, 24'sd3, 1);
   endtask

   task automatic test_random();
      int target, n, mode, last_part;
      target = items_sent + 1150;
      last_part = target - 150;
      while (items_sent < target) begin
         if (items_sent >= last_part) quiet = 1;
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
         mode = $urandom_range(0, 3);
         for (int k = 0; k < n; k++)
            send_point(rand_coord(mode), rand_coord(mode), rand_coord(mode), k == n - 1);
      end
   endtask

   initial begin
      int waited;
      clear_set();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_single_and_coincident();
      test_ties();
      test_store_full();
      test_random();
      req_valid <= 1'b0;
      waited = 0;
      while (expected_spheres.size() != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (100) @(posedge clock);
      if (expected_spheres.size() != 0) begin
         errors++;
         $display("%0d spheres never arrived", expected_spheres.size());
      end
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
